// File: design/rau_pkg.sv
package rau_pkg;

  localparam int WORD_BITS = 32;
  localparam int CNT_BITS = $clog2(WORD_BITS + 1);
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_BITS = $clog2(QUEUE_DEPTH);

  typedef logic [WORD_BITS-1:0] word_t;

  typedef enum logic [2:0] {
    OP_NORM = 3'd0,
    OP_ADD  = 3'd1,
    OP_SUB  = 3'd2,
    OP_MUL  = 3'd3,
    OP_DIV  = 3'd4
  } op_t;

  typedef struct packed {
    logic [2:0]         req_type;
    logic signed [31:0] a_num;
    logic signed [31:0] a_den;
    logic signed [31:0] b_num;
    logic signed [31:0] b_den;
  } req_t;

  typedef struct packed {
    logic signed [31:0] res_num;
    logic [30:0]        res_den;
    logic               div_zero;
  } res_t;

  typedef struct packed {
    op_t   op;
    word_t a_num;
    word_t a_den;
    word_t b_num;
    word_t b_den;
  } job_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_LOAD,
    S_MKA,
    S_MKB,
    S_ADD_G,
    S_ADD_D,
    S_ADD_L,
    S_ADD_Q1,
    S_ADD_Q2,
    S_ADD_S,
    S_MUL,
    S_RECIP,
    S_SUB_NEG,
    S_FIN,
    S_MF_G,
    S_MF_D1,
    S_MF_D2,
    S_MF_END,
    S_DONE
  } state_t;

  typedef enum logic [1:0] {
    RET_A,
    RET_B,
    RET_T,
    RET_R
  } ret_t;

  typedef struct packed {
    logic  start;
    logic  is_gcd;
    word_t x;
    word_t y;
  } ar_req_t;

  typedef struct packed {
    logic  done;
    word_t q;
    word_t g;
  } ar_rsp_t;

  function automatic logic w_isneg(word_t x);
    return x[WORD_BITS-1];
  endfunction

  function automatic word_t w_mag(word_t x);
    return x[WORD_BITS-1] ? word_t'(-x) : x;
  endfunction

  function automatic word_t sext_in(logic [31:0] v);
    logic [63:0] e;
    e = {{32{v[31]}}, v};
    return e[WORD_BITS-1:0];
  endfunction

endpackage

// File: design/rau_front.sv
module rau_front (
  input  logic          start,
  output logic          busy,
  input  rau_pkg::req_t req,
  output logic          q_push,
  output rau_pkg::job_t q_data,
  input  logic          q_full
);
  import rau_pkg::*;

  op_t op_dec;

  assign busy = q_full;
  assign q_push = start && !q_full;

  always_comb begin
    unique case (req.req_type)
      OP_ADD: op_dec = OP_ADD;
      OP_SUB: op_dec = OP_SUB;
      OP_MUL: op_dec = OP_MUL;
      OP_DIV: op_dec = OP_DIV;
      default: op_dec = OP_NORM;
    endcase
  end

  always_comb begin
    q_data.op = op_dec;
    q_data.a_num = sext_in(req.a_num);
    q_data.a_den = sext_in(req.a_den);
    q_data.b_num = sext_in(req.b_num);
    q_data.b_den = sext_in(req.b_den);
  end

endmodule

// File: design/rau_queue.sv
module rau_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  rau_pkg::job_t push_data,
  output logic          full,
  input  logic          pop,
  output logic          empty,
  output rau_pkg::job_t pop_data
);
  import rau_pkg::*;

  job_t mem [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wr_ptr;
  logic [QPTR_BITS-1:0] rd_ptr;
  logic [QPTR_BITS:0]   count;

  assign full = (count == (QPTR_BITS+1)'(QUEUE_DEPTH));
  assign empty = (count == '0);
  assign pop_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push && !full) wr_ptr <= wr_ptr + 1'b1;
      if (pop && !empty) rd_ptr <= rd_ptr + 1'b1;
      count <= count + (QPTR_BITS+1)'(push && !full) - (QPTR_BITS+1)'(pop && !empty);
    end
  end

  assert property (@(posedge clk) disable iff (rst) full |-> !empty)
    else $error("queue full and empty");
  assert property (@(posedge clk) disable iff (rst) (empty && !push) |=> empty)
    else $error("queue filled without push");
  assert property (@(posedge clk) disable iff (rst)
    (full && !pop) |=> full)
    else $error("queue drained without pop");

endmodule

// File: design/rau_arith.sv
module rau_arith (
  input  logic             clk,
  input  logic             rst,
  input  rau_pkg::ar_req_t req,
  output rau_pkg::ar_rsp_t rsp
);
  import rau_pkg::*;

  // restoring divider, one quotient bit a cycle; gcd iterates remainders
  logic          active;
  logic          gcd_mode;
  logic          dividing;
  word_t         u;
  word_t         v;
  word_t         dvd;
  word_t         dvs;
  word_t         quo;
  logic [WORD_BITS:0] rem;
  logic [CNT_BITS-1:0] cnt;
  logic                u_ge_v;
  logic [WORD_BITS:0]  trial;
  logic [WORD_BITS:0]  rem_sh;

  assign u_ge_v = (u >= v);
  assign rem_sh = {rem[WORD_BITS-1:0], dvd[WORD_BITS-1]};
  assign trial = rem_sh - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      dividing <= 1'b0;
      rsp.done <= 1'b0;
    end else begin
      rsp.done <= 1'b0;
      if (req.start && !active) begin
        active <= 1'b1;
        gcd_mode <= req.is_gcd;
        u <= req.x;
        v <= req.y;
        if (!req.is_gcd) begin
          dividing <= 1'b1;
          dvd <= req.x;
          dvs <= req.y;
          rem <= '0;
          quo <= '0;
          cnt <= CNT_BITS'(WORD_BITS);
        end else begin
          dividing <= 1'b0;
        end
      end else if (active && !dividing) begin
        if (u == '0 || v == '0) begin
          active <= 1'b0;
          rsp.done <= 1'b1;
          rsp.g <= u | v;
        end else begin
          dividing <= 1'b1;
          dvd <= u_ge_v ? u : v;
          dvs <= u_ge_v ? v : u;
          rem <= '0;
          quo <= '0;
          cnt <= CNT_BITS'(WORD_BITS);
        end
      end else if (active && dividing) begin
        dvd <= {dvd[WORD_BITS-2:0], 1'b0};
        if (!trial[WORD_BITS]) begin
          rem <= trial;
          quo <= {quo[WORD_BITS-2:0], 1'b1};
        end else begin
          rem <= rem_sh;
          quo <= {quo[WORD_BITS-2:0], 1'b0};
        end
        cnt <= cnt - 1'b1;
        if (cnt == CNT_BITS'(1)) begin
          dividing <= 1'b0;
          if (!gcd_mode) begin
            active <= 1'b0;
            rsp.done <= 1'b1;
            rsp.q <= !trial[WORD_BITS] ? {quo[WORD_BITS-2:0], 1'b1}
                                        : {quo[WORD_BITS-2:0], 1'b0};
          end else if (u_ge_v) begin
            u <= !trial[WORD_BITS] ? trial[WORD_BITS-1:0] : rem_sh[WORD_BITS-1:0];
          end else begin
            v <= !trial[WORD_BITS] ? trial[WORD_BITS-1:0] : rem_sh[WORD_BITS-1:0];
          end
        end
      end
    end
  end

  assert property (@(posedge clk) disable iff (rst) rsp.done |=> !rsp.done)
    else $error("double done");
  assert property (@(posedge clk) disable iff (rst) rsp.done |-> !active)
    else $error("done while active");
  assert property (@(posedge clk) disable iff (rst) dividing |-> active)
    else $error("divide without job");

endmodule

// File: design/rau_back.sv
module rau_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          q_empty,
  input  rau_pkg::job_t q_data,
  output logic          q_pop,
  output logic          strobe,
  output rau_pkg::res_t result
);
  import rau_pkg::*;

  state_t state, state_next;
  job_t   job;
  ret_t   ret;
  word_t  an, ad, bn, bd, tn, td, rn, rd;
  word_t  mk_n, mk_d, mn, md, gg;
  logic   mk_neg;
  word_t  l, q1, p1;
  logic   ok;
  logic   ar_busy;
  ar_req_t ar_req;
  ar_rsp_t ar_rsp;
  logic   mk_bad;
  word_t  prod;
  logic [2*WORD_BITS-1:0] prod_w;
  word_t  mul_x, mul_y;

  rau_arith u_arith (.clk(clk), .rst(rst), .req(ar_req), .rsp(ar_rsp));

  assign prod_w = mul_x * mul_y;
  assign prod = prod_w[WORD_BITS-1:0];

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (!q_empty) state_next = S_LOAD;
      S_LOAD: state_next = S_MF_G;
      S_MF_G: begin
        if (mk_bad) state_next = S_DONE;
        else if (ar_rsp.done) state_next = S_MF_D1;
      end
      S_MF_D1: if (ar_rsp.done) state_next = S_MF_D2;
      S_MF_D2: if (ar_rsp.done) state_next = S_MF_END;
      S_MF_END: begin
        if (!ok || md[WORD_BITS-1]) state_next = S_DONE;
        else begin
          unique case (ret)
            RET_A: state_next = (job.op == OP_NORM) ? S_FIN : S_MKB;
            RET_B: begin
              unique case (job.op)
                OP_ADD: state_next = S_ADD_G;
                OP_SUB: state_next = S_SUB_NEG;
                OP_MUL: state_next = S_MUL;
                default: state_next = S_RECIP;
              endcase
            end
            RET_T: state_next = (job.op == OP_SUB) ? S_ADD_G : S_MUL;
            default: state_next = S_DONE;
          endcase
        end
      end
      S_MKB: state_next = S_MF_G;
      S_SUB_NEG: state_next = S_MF_G;
      S_RECIP: state_next = S_MF_G;
      S_ADD_G: if (ar_rsp.done) state_next = S_ADD_D;
      S_ADD_D: if (ar_rsp.done) state_next = S_ADD_L;
      S_ADD_L: state_next = S_ADD_Q1;
      S_ADD_Q1: if (ar_rsp.done) state_next = S_ADD_Q2;
      S_ADD_Q2: if (ar_rsp.done) state_next = S_ADD_S;
      S_ADD_S: state_next = S_MF_G;
      S_MUL: state_next = S_MKA;
      S_MKA: state_next = S_MF_G;
      S_FIN: state_next = S_DONE;
      S_DONE: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    q_pop = (state == S_IDLE) && !q_empty;
    mk_bad = (mk_d == '0);
    mul_x = '0;
    mul_y = '0;
    unique case (state)
      S_ADD_L: begin mul_x = q1; mul_y = (ret == RET_B) ? bd : td; end
      S_ADD_S: begin mul_x = an; mul_y = q1; end
      S_MUL: begin mul_x = an; mul_y = (job.op == OP_DIV) ? tn : bn; end
      S_MKA: begin mul_x = ad; mul_y = (job.op == OP_DIV) ? td : bd; end
      default: ;
    endcase
  end

  // arithmetic unit requests
  always_ff @(posedge clk) begin
    if (rst) begin
      ar_busy <= 1'b0;
      ar_req <= '0;
    end else begin
      ar_req.start <= 1'b0;
      if (ar_rsp.done) ar_busy <= 1'b0;
      if (!ar_busy && !ar_req.start && !ar_rsp.done) begin
        priority case (state)
          S_MF_G: if (!mk_bad) begin
            ar_req <= '{start: 1'b1, is_gcd: 1'b1, x: w_mag(mk_n), y: w_mag(mk_d)};
            ar_busy <= 1'b1;
          end
          S_MF_D1: begin
            ar_req <= '{start: 1'b1, is_gcd: 1'b0, x: mn, y: gg};
            ar_busy <= 1'b1;
          end
          S_MF_D2: begin
            ar_req <= '{start: 1'b1, is_gcd: 1'b0, x: md, y: gg};
            ar_busy <= 1'b1;
          end
          S_ADD_G: begin
            ar_req <= '{start: 1'b1, is_gcd: 1'b1, x: ad,
                        y: (ret == RET_B) ? bd : td};
            ar_busy <= 1'b1;
          end
          S_ADD_D: begin
            ar_req <= '{start: 1'b1, is_gcd: 1'b0, x: ad, y: gg};
            ar_busy <= 1'b1;
          end
          S_ADD_Q1: begin
            ar_req <= '{start: 1'b1, is_gcd: 1'b0, x: w_mag(l), y: ad};
            ar_busy <= 1'b1;
          end
          S_ADD_Q2: begin
            ar_req <= '{start: 1'b1, is_gcd: 1'b0, x: w_mag(l),
                        y: (ret == RET_B) ? bd : td};
            ar_busy <= 1'b1;
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: if (!q_empty) job <= q_data;
      S_LOAD: begin
        mk_n <= job.a_num; mk_d <= job.a_den; ret <= RET_A; ok <= 1'b1;
      end
      S_MF_G: begin
        mk_neg <= w_isneg(mk_n) != w_isneg(mk_d);
        mn <= w_mag(mk_n);
        md <= w_mag(mk_d);
        if (mk_bad) ok <= 1'b0;
        if (ar_rsp.done) gg <= ar_rsp.g;
      end
      S_MF_D1: if (ar_rsp.done) mn <= ar_rsp.q;
      S_MF_D2: if (ar_rsp.done) md <= ar_rsp.q;
      S_MF_END: begin
        if (md[WORD_BITS-1]) ok <= 1'b0;
        unique case (ret)
          RET_A: begin an <= mk_neg ? word_t'(-mn) : mn; ad <= md; end
          RET_B: begin bn <= mk_neg ? word_t'(-mn) : mn; bd <= md; end
          RET_T: begin tn <= mk_neg ? word_t'(-mn) : mn; td <= md; end
          default: begin rn <= mk_neg ? word_t'(-mn) : mn; rd <= md; end
        endcase
      end
      S_MKB: begin mk_n <= job.b_num; mk_d <= job.b_den; ret <= RET_B; end
      S_SUB_NEG: begin mk_n <= word_t'(-bn); mk_d <= bd; ret <= RET_T; end
      S_RECIP: begin mk_n <= bd; mk_d <= bn; ret <= RET_T; end
      S_ADD_G: if (ar_rsp.done) gg <= ar_rsp.g;
      S_ADD_D: if (ar_rsp.done) q1 <= ar_rsp.q;
      S_ADD_L: begin
        l <= prod;
        if (prod == '0) ok <= 1'b0;
      end
      S_ADD_Q1: if (ar_rsp.done) q1 <= w_isneg(l) ? word_t'(-ar_rsp.q) : ar_rsp.q;
      S_ADD_Q2: if (ar_rsp.done) p1 <= w_isneg(l) ? word_t'(-ar_rsp.q) : ar_rsp.q;
      S_ADD_S: begin
        mk_n <= prod + word_t'((ret == RET_B ? bn : tn) * p1);
        mk_d <= l;
        ret <= RET_R;
      end
      S_MUL: tn <= prod;
      S_MKA: begin mk_n <= tn; mk_d <= prod; ret <= RET_R; end
      S_FIN: begin rn <= an; rd <= ad; end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= (state == S_DONE);
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE) begin
      result.div_zero <= !ok;
      result.res_num <= ok ? 32'(signed'(rn)) : '0;
      result.res_den <= ok ? 31'(rd) : '0;
    end
  end

  assert property (@(posedge clk) disable iff (rst) strobe |=> !strobe)
    else $error("result strobe held");
  assert property (@(posedge clk) disable iff (rst) q_pop |=> state == S_LOAD)
    else $error("pop without load");
  assert property (@(posedge clk) disable iff (rst)
    (strobe && result.div_zero) |-> (result.res_den == '0))
    else $error("error result not cleared");

endmodule

// File: design/rational_arithmetic_unit.sv
// rational arithmetic unit
// present a transaction on req with start high; it is taken when busy is low
// req_type selects normalize, add, subtract, multiply or divide of a and b
// the result comes back on result for exactly one cycle with strobe high
// the receiver cannot stall: every result must be taken as it appears
// a two-entry queue sits between the front end and the execution engine
// so up to two further transactions may be taken while one is worked on
// latency is data dependent: each reduction runs a euclidean gcd whose steps
// are each a 33-cycle bit-serial division, followed by two such divisions
// an add also spends a gcd and three divisions on the common denominator
// typical latency is a few hundred cycles, worst case under ten thousand
// the engine works on one transaction at a time, so throughput is one
// transaction per latency once the queue has filled
// a zero or unrepresentable denominator gives div_zero with zero fields
// reset clears the queue and returns the engine to idle; work in flight is dropped
// results come back in order of acceptance
module rational_arithmetic_unit (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  rau_pkg::req_t req,
  output logic          strobe,
  output rau_pkg::res_t result
);
  import rau_pkg::*;

  logic q_push, q_full, q_pop, q_empty;
  job_t q_in, q_out;

  rau_front u_front (.start(start), .busy(busy), .req(req),
                     .q_push(q_push), .q_data(q_in), .q_full(q_full));

  rau_queue u_queue (.clk(clk), .rst(rst), .push(q_push), .push_data(q_in),
                     .full(q_full), .pop(q_pop), .empty(q_empty), .pop_data(q_out));

  rau_back u_back (.clk(clk), .rst(rst), .q_empty(q_empty), .q_data(q_out),
                   .q_pop(q_pop), .strobe(strobe), .result(result));

endmodule

// File: tb/rational_arithmetic_unit_test.sv
module rational_arithmetic_unit_test;
  import rau_pkg::*;

  class fraction_scoreboard;
    res_t pending[$];
    int errors;

    function new();
      errors = 0;
    endfunction

    static function logic [63:0] gcd64(logic [63:0] u, logic [63:0] v);
      while (u != 0 && v != 0) begin
        if (u >= v) begin
          u = u % v;
        end else begin
          v = v % u;
        end
      end
      return u + v;
    endfunction

    static function logic [31:0] mag32(logic [31:0] x);
      return x[31] ? -x : x;
    endfunction

    // signed word over positive divisor, truncating towards zero
    static function logic [31:0] div_pos(logic [31:0] x, logic [31:0] d);
      logic [31:0] q;
      q = mag32(x) / d;
      return x[31] ? -q : q;
    endfunction

    static function bit reduce(logic [31:0] n, logic [31:0] d,
                               output logic [31:0] rn, output logic [31:0] rd);
      logic [63:0] mn, md, g;
      rn = 0;
      rd = 0;
      if (d == 0) return 0;
      mn = {32'd0, mag32(n)};
      md = {32'd0, mag32(d)};
      g = gcd64(mn, md);
      mn = mn / g;
      md = md / g;
      if (md > 64'h7fff_ffff) return 0;
      rn = (n[31] != d[31]) ? -mn[31:0] : mn[31:0];
      rd = md[31:0];
      return 1;
    endfunction

    static function bit sum_frac(logic [31:0] xn, logic [31:0] xd, logic [31:0] yn,
                                 logic [31:0] yd, output logic [31:0] rn,
                                 output logic [31:0] rd);
      logic [63:0] g;
      logic [31:0] l, s;
      g = gcd64({32'd0, xd}, {32'd0, yd});
      l = (xd / g[31:0]) * yd;
      s = xn * div_pos(l, xd) + yn * div_pos(l, yd);
      return reduce(s, l, rn, rd);
    endfunction

    function res_t predict_fraction(req_t q);
      logic [31:0] an, ad, bn, bd, tn, td, rn, rd;
      bit ok;
      res_t r;
      ok = reduce(q.a_num, q.a_den, an, ad);
      rn = an;
      rd = ad;
      if (ok && q.req_type >= OP_ADD && q.req_type <= OP_DIV)
        ok = reduce(q.b_num, q.b_den, bn, bd);
      if (ok) begin
        case (q.req_type)
          OP_ADD: ok = sum_frac(an, ad, bn, bd, rn, rd);
          OP_SUB: ok = reduce(-bn, bd, tn, td) && sum_frac(an, ad, tn, td, rn, rd);
          OP_MUL: ok = reduce(an * bn, ad * bd, rn, rd);
          OP_DIV: ok = reduce(bd, bn, tn, td) && reduce(an * tn, ad * td, rn, rd);
          default: ;
        endcase
      end
      r.res_num = ok ? rn : 0;
      r.res_den = ok ? rd[30:0] : 0;
      r.div_zero = !ok;
      return r;
    endfunction

    function void note_request(req_t q);
      pending.push_back(predict_fraction(q));
    endfunction

    function void check_result(res_t got);
      res_t e;
      if (pending.size() == 0) begin
        report_mismatch("result with nothing outstanding", 0, got);
        return;
      end
      e = pending.pop_front();
      if (got.res_num !== e.res_num) report_mismatch("res_num", e, got);
      if (got.res_den !== e.res_den) report_mismatch("res_den", e, got);
      if (got.div_zero !== e.div_zero) report_mismatch("div_zero", e, got);
    endfunction

    function void report_mismatch(string what, res_t e, res_t got);
      errors++;
      $display("mismatch %s: expected %0d/%0d z%0d got %0d/%0d z%0d", what,
               e.res_num, e.res_den, e.div_zero, got.res_num, got.res_den,
               got.div_zero);
    endfunction
  endclass

  localparam int WATCHDOG_LIMIT = 200000;

  logic clk = 0;
  logic rst = 1;
  logic start = 0;
  logic busy;
  logic strobe;
  req_t req = '0;
  res_t result;
  fraction_scoreboard board = new();
  int idle_cycles = 0;

  always #2 clk = ~clk;

  rational_arithmetic_unit i_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .req(req),
    .strobe(strobe), .result(result)
  );

  always @(posedge clk) begin
    if (!rst && strobe) board.check_result(result);
    if (!rst && ((start && !busy) || strobe)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 6))
      0: return $urandom;
      1: return 32'h8000_0000 + $urandom_range(0, 2);
      2: return 32'h7fff_ffff - $urandom_range(0, 2);
      3: return $urandom_range(0, 2) - 1;
      4: return $urandom_range(0, 60) - 30;
      5: return ($urandom_range(1, 4000) * $urandom_range(1, 4000)) * ($urandom & 1 ? -1 : 1);
      default: return $urandom_range(0, 1000) - 500;
    endcase
  endfunction

  task automatic send_request(logic [2:0] kind, logic [31:0] an, logic [31:0] ad,
                              logic [31:0] bn, logic [31:0] bd);
    int gap;
    gap = $urandom_range(0, 17);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap != 0) begin
      start <= 0;
      repeat (gap) @(posedge clk);
    end
    req <= '{req_type: kind, a_num: an, a_den: ad, b_num: bn, b_den: bd};
    start <= 1;
    do @(posedge clk); while (busy);
    board.note_request('{req_type: kind, a_num: an, a_den: ad, b_num: bn, b_den: bd});
  endtask

  task automatic drain_results();
    start <= 0;
    while (board.pending.size() != 0) @(posedge clk);
  endtask

  initial begin
    logic [2:0] kind;
    repeat (7) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    send_request(OP_NORM, 6, -4, 0, 0);
    send_request(OP_NORM, 5, 0, 1, 1);
    send_request(OP_NORM, 32'h8000_0000, -1, 0, 0);
    send_request(OP_NORM, 1, 32'h8000_0000, 0, 0);
    send_request(OP_NORM, 32'h8000_0000, 32'h8000_0000, 0, 0);
    send_request(OP_NORM, 32'h7fff_ffff, 32'hffff_ffff, 0, 0);
    send_request(OP_ADD, 1, 2, 1, 3);
    send_request(OP_ADD, 1, 0, 1, 3);
    send_request(OP_ADD, 1, 3, 1, 0);
    send_request(OP_ADD, 1, 65536, 1, 65535);
    send_request(OP_SUB, 1, 2, 1, 2);
    send_request(OP_SUB, 3, 4, 32'h8000_0000, 1);
    send_request(OP_MUL, 2, 3, -3, 4);
    send_request(OP_MUL, 1, 65536, 1, 32768);
    send_request(OP_MUL, 32'h7fff_ffff, 1, 32'h7fff_ffff, 1);
    send_request(OP_DIV, 2, 3, 4, 5);
    send_request(OP_DIV, 2, 3, 0, 5);
    send_request(OP_DIV, -7, 3, -2, 9);
    send_request(3'd5, 10, 4, 1, 1);
    send_request(3'd6, -9, 3, 0, 0);
    send_request(3'd7, 0, -5, 0, 0);
    drain_results();
    for (int i = 0; i < 1100; i++) begin
      kind = 3'($urandom_range(0, 7));
      if ($urandom_range(0, 9) != 0) kind = 3'($urandom_range(0, 4));
      send_request(kind, pick_value(), pick_value(), pick_value(), pick_value());
      if (i == 550) drain_results();
    end
    drain_results();
    repeat (100) @(posedge clk);
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule
